>>> sv/hsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types, codes and coding functions for the Hamming / SECDED byte codec.
// No dependencies; the top, front end, queue and sequencer use this package.
package hsc_pkg;

  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  localparam logic KIND_CODEWORD = 1'b0;
  localparam logic KIND_BYTE     = 1'b1;

  // One queued job: a codeword pair (two results) or a decoded byte (one result)
  typedef struct packed {
    logic       kind;
    logic [7:0] value_hi;
    logic [7:0] value_lo;
    logic [1:0] error_count;
    logic       uncorrectable;
  } hsc_job_t;

  typedef struct packed {
    logic     valid;
    hsc_job_t job;
  } hsc_head_t;

  // XOR of the indices of the set bits in positions 1..7
  function automatic logic [2:0] syndrome(input logic [7:0] cw);
    logic [2:0] s;
    s = '0;
    for (int k = 1; k < 8; k++) begin
      if (cw[k]) begin
        s = s ^ 3'(k);
      end
    end
    return s;
  endfunction

  function automatic logic [7:0] build_codeword(input logic [3:0] nib, input logic ext);
    logic [7:0] cw;
    logic [2:0] s;
    cw = {nib[0], nib[1], nib[2], 1'b0, nib[3], 3'b000};
    s = syndrome(cw);
    cw[1] = s[0];
    cw[2] = s[1];
    cw[4] = s[2];
    if (ext) begin
      cw[0] = ^cw;
    end
    return cw;
  endfunction

  function automatic logic [3:0] extract_nibble(input logic [7:0] cw);
    return {cw[3], cw[5], cw[6], cw[7]};
  endfunction

endpackage : hsc_pkg
`default_nettype wire

>>> sv/hsc_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Input channel of the codec: valid/ready handshake with opcode and data byte.
// No dependencies.
interface hsc_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] data_in;

  modport source (output valid, output opcode, output data_in, input ready);
  modport sink   (input valid, input opcode, input data_in, output ready);
endinterface : hsc_in_if
`default_nettype wire

>>> sv/hsc_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Result channel of the codec: valid/ready handshake with the result fields.
// No dependencies.
interface hsc_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] value;
  logic       last;
  logic [1:0] error_count;
  logic       uncorrectable;

  modport source (output valid, output kind, output value, output last,
                  output error_count, output uncorrectable, input ready);
  modport sink   (input valid, input kind, input value, input last,
                  input error_count, input uncorrectable, output ready);
endinterface : hsc_out_if
`default_nettype wire

>>> sv/hamming_secded_byte_codec.sv
`timescale 1ns / 1ps
`default_nettype none
// Hamming(7,4) / SECDED(8,4) byte codec.
// in_ch carries opcode and data_in. Encode turns a byte into two codewords,
// high nibble first; decode takes one codeword per transfer and, after two,
// returns the corrected byte with error count and double-error flag.
// out_ch carries kind, value, last, error_count and uncorrectable.
// cfg_we/cfg_wdata write extended_mode (reset 1 = SECDED); write it only while idle.
// A completed job is written into the job queue and offered from its head.
// Throughput: one input transfer per cycle while the job queue has room; an
// encode gives two results, so the result port sets the pace for encoded bytes,
// and a decoded pair gives one result per two inputs. The front end decodes
// combinationally; the QUEUE_DEPTH-entry queue parts it from the result sequencer.
// in_ch.ready depends only on queue occupancy, never on out_ch.ready, so a
// stalled receiver fills the queue and then holds the input off.
// Reset (synchronous, rst_n low) empties the queue, drops any held first
// half and sets extended mode.
// Depends on hsc_pkg, hsc_in_if, hsc_out_if, hsc_front, hsc_fifo, hsc_back.
module hamming_secded_byte_codec #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst_n,
  hsc_in_if.sink    in_ch,
  hsc_out_if.source out_ch,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata
);

  logic               q_ready;
  logic               q_wr_en;
  hsc_pkg::hsc_job_t  q_wr_job;
  logic               q_rd_en;
  hsc_pkg::hsc_head_t q_head;

  hsc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_ready   (q_ready),
    .q_wr_en   (q_wr_en),
    .q_wr_job  (q_wr_job)
  );

  hsc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_wr_en),
    .wr_job   (q_wr_job),
    .wr_ready (q_ready),
    .rd_en    (q_rd_en),
    .head     (q_head)
  );

  hsc_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (q_head),
    .rd_en  (q_rd_en),
    .out_ch (out_ch)
  );

endmodule : hamming_secded_byte_codec
`default_nettype wire

>>> sv/hsc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Front end: takes input transfers, encodes or decodes/corrects, pairs decoded halves.
// Depends on hsc_pkg and hsc_in_if.
module hsc_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  hsc_in_if.sink             in_ch,
  input  wire logic          cfg_we,
  input  wire logic          cfg_wdata,
  input  wire logic          q_ready,
  output      logic          q_wr_en,
  output      hsc_pkg::hsc_job_t q_wr_job
);

  logic       ext_mode_r, ext_mode_nxt;
  logic       half_seen_r, half_seen_nxt;
  logic [3:0] held_nibble_r, held_nibble_nxt;
  logic       held_error_r, held_error_nxt;
  logic       held_fatal_r, held_fatal_nxt;

  logic       accept;
  logic [2:0] syn;
  logic       par;
  logic [7:0] fixed_cw;
  logic       blk_err;
  logic       blk_fatal;
  logic [3:0] nib;

  assign in_ch.ready = q_ready;
  assign accept      = in_ch.valid && q_ready;

  assign syn = hsc_pkg::syndrome(in_ch.data_in);
  assign par = ^in_ch.data_in;

  always_comb begin
    fixed_cw  = in_ch.data_in;
    blk_err   = 1'b0;
    blk_fatal = 1'b0;
    if (ext_mode_r) begin
      if (syn != 3'd0) begin
        blk_err = 1'b1;
        if (par) begin
          fixed_cw = in_ch.data_in ^ (8'd1 << syn);
        end else begin
          // even parity with a nonzero syndrome: double error, leave the data
          blk_fatal = 1'b1;
        end
      end else if (par) begin
        // only the overall parity bit is wrong
        blk_err  = 1'b1;
        fixed_cw = in_ch.data_in ^ 8'd1;
      end
    end else if (syn != 3'd0) begin
      blk_err  = 1'b1;
      fixed_cw = in_ch.data_in ^ (8'd1 << syn);
    end
  end

  assign nib = hsc_pkg::extract_nibble(fixed_cw);

  always_comb begin
    q_wr_job = '0;
    if (in_ch.opcode == hsc_pkg::OP_ENCODE) begin
      q_wr_job.kind     = hsc_pkg::KIND_CODEWORD;
      q_wr_job.value_hi = hsc_pkg::build_codeword(in_ch.data_in[7:4], ext_mode_r);
      q_wr_job.value_lo = hsc_pkg::build_codeword(in_ch.data_in[3:0], ext_mode_r);
    end else begin
      q_wr_job.kind          = hsc_pkg::KIND_BYTE;
      q_wr_job.value_hi      = {held_nibble_r, nib};
      q_wr_job.error_count   = {1'b0, held_error_r} + {1'b0, blk_err};
      q_wr_job.uncorrectable = held_fatal_r | blk_fatal;
    end
  end

  // a first decoded half produces nothing; hold it instead
  assign q_wr_en = accept && ((in_ch.opcode == hsc_pkg::OP_ENCODE) || half_seen_r);

  always_comb begin
    ext_mode_nxt    = cfg_we ? cfg_wdata : ext_mode_r;
    half_seen_nxt   = half_seen_r;
    held_nibble_nxt = held_nibble_r;
    held_error_nxt  = held_error_r;
    held_fatal_nxt  = held_fatal_r;
    if (accept && (in_ch.opcode == hsc_pkg::OP_DECODE)) begin
      if (half_seen_r) begin
        half_seen_nxt   = 1'b0;
        held_nibble_nxt = '0;
        held_error_nxt  = 1'b0;
        held_fatal_nxt  = 1'b0;
      end else begin
        half_seen_nxt   = 1'b1;
        held_nibble_nxt = nib;
        held_error_nxt  = blk_err;
        held_fatal_nxt  = blk_fatal;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_mode_r    <= 1'b1;
      half_seen_r   <= 1'b0;
      held_nibble_r <= '0;
      held_error_r  <= 1'b0;
      held_fatal_r  <= 1'b0;
    end else begin
      ext_mode_r    <= ext_mode_nxt;
      half_seen_r   <= half_seen_nxt;
      held_nibble_r <= held_nibble_nxt;
      held_error_r  <= held_error_nxt;
      held_fatal_r  <= held_fatal_nxt;
    end
  end

endmodule : hsc_front
`default_nettype wire

>>> sv/hsc_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// Short job queue between the front end and the result sequencer.
// Depends on hsc_pkg.
module hsc_fifo #(
  parameter int DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire hsc_pkg::hsc_job_t wr_job,
  output      logic              wr_ready,
  input  wire logic              rd_en,
  output      hsc_pkg::hsc_head_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  hsc_pkg::hsc_job_t mem [DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign wr_ready   = (count_r != FULL_CNT);
  assign head.valid = (count_r != '0);
  assign head.job   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (count_r != FULL_CNT))
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (count_r != '0))
    else $error("job queue read while empty");

endmodule : hsc_fifo
`default_nettype wire

>>> sv/hsc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// Result sequencer: plays out each queued job as one or two result transfers.
// Depends on hsc_pkg and hsc_out_if.
module hsc_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire hsc_pkg::hsc_head_t head,
  output      logic               rd_en,
  hsc_out_if.source               out_ch
);

  logic phase_r, phase_nxt;
  logic is_pair;
  logic xfer;

  assign is_pair = (head.job.kind == hsc_pkg::KIND_CODEWORD);
  assign xfer    = out_ch.valid && out_ch.ready;

  assign out_ch.valid         = head.valid;
  assign out_ch.kind          = head.job.kind;
  assign out_ch.value         = (is_pair && phase_r) ? head.job.value_lo : head.job.value_hi;
  assign out_ch.last          = !is_pair || phase_r;
  assign out_ch.error_count   = head.job.error_count;
  assign out_ch.uncorrectable = head.job.uncorrectable;

  // drop the job once its final result has gone
  assign rd_en = xfer && out_ch.last;

  always_comb begin
    phase_nxt = phase_r;
    if (xfer) begin
      phase_nxt = !out_ch.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  a_phase_on_pair: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (head.valid && is_pair))
    else $error("second half pending without a codeword pair at the head");

  a_low_follows_high: assert property (@(posedge clk) disable iff (!rst_n)
    (xfer && is_pair && !phase_r) |=> (phase_r && !rd_en || out_ch.valid))
    else $error("low codeword not presented after high codeword");

endmodule : hsc_back
`default_nettype wire
